### hdl/imu_angle_frame_parser_defines.svh
// Assertion macros shared by the checker of the IMU angle frame parser.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef IMU_ANGLE_FRAME_PARSER_DEFINES_SVH
`define IMU_ANGLE_FRAME_PARSER_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define AFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imu_angle_frame_parser check failed");

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define AFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imu_angle_frame_parser check failed");

`endif

### hdl/imu_afp_pkg.sv
// Package of the IMU angle frame parser: register map, reset values and types.
// Used by the register file, the framer and the top level; depends on nothing.
`timescale 1ns / 1ps

package imu_afp_pkg;

    // Configuration port geometry: two 8-bit registers in 32-bit words at byte addresses 0 and 4.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index as decoded from paddr bit 2.
    localparam logic REG_HEADER_BYTE     = 1'b0;
    localparam logic REG_ANGLE_TYPE_CODE = 1'b1;

    // Register reset values.
    localparam logic [7:0] HEADER_BYTE_RESET     = 8'h55;
    localparam logic [7:0] ANGLE_TYPE_CODE_RESET = 8'h53;

    // Frame layout.
    localparam int PAYLOAD_BYTES = 8;
    localparam int PAYLOAD_START = 2;
    localparam int COUNT_W       = 4;

    // Current configuration, handed from the register file to the framer.
    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] angle_type_code;
    } afp_cfg_t;

    // One unpacked angle frame.
    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic signed [15:0] temperature_raw;
    } afp_result_t;

endpackage

### hdl/imu_afp_regs.sv
// APB-style configuration registers of the IMU angle frame parser.
// Depends on imu_afp_pkg for the register map and reset values.
`timescale 1ns / 1ps

module imu_afp_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [imu_afp_pkg::PADDR_W-1:0] paddr,
    input  logic [imu_afp_pkg::PDATA_W-1:0] pwdata,
    output logic [imu_afp_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output imu_afp_pkg::afp_cfg_t        cfg
);
    import imu_afp_pkg::*;

    logic [7:0] header_byte_reg;
    logic [7:0] angle_type_code_reg;
    logic       wr_en;
    logic       reg_sel;

    // Zero wait states: every access completes in its access cycle.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // Register writes; the low address bits are not decoded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_byte_reg     <= HEADER_BYTE_RESET;
            angle_type_code_reg <= ANGLE_TYPE_CODE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_HEADER_BYTE:     header_byte_reg     <= pwdata[7:0];
                REG_ANGLE_TYPE_CODE: angle_type_code_reg <= pwdata[7:0];
                default:             header_byte_reg     <= header_byte_reg;
            endcase
        end
    end

    // Read data mux.
    always_comb
    begin
        case (reg_sel)
            REG_HEADER_BYTE:     prdata = {{(PDATA_W-8){1'b0}}, header_byte_reg};
            REG_ANGLE_TYPE_CODE: prdata = {{(PDATA_W-8){1'b0}}, angle_type_code_reg};
            default:             prdata = '0;
        endcase
    end

    assign cfg.header_byte     = header_byte_reg;
    assign cfg.angle_type_code = angle_type_code_reg;

endmodule

### hdl/imu_afp_framer.sv
// Frame assembly of the IMU angle frame parser: byte counter, type and payload store.
// Depends on imu_afp_pkg for the configuration and result types.
`timescale 1ns / 1ps

module imu_afp_framer
#(
    parameter int FRAME_LENGTH = 11
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [7:0]               rx_byte,
    input  imu_afp_pkg::afp_cfg_t    cfg,
    output logic                     res_valid,
    output imu_afp_pkg::afp_result_t res
);
    import imu_afp_pkg::*;

    localparam logic [COUNT_W:0] LAST_POS = (COUNT_W+1)'(FRAME_LENGTH - 1);

    logic [COUNT_W-1:0] byte_count_reg;
    logic [COUNT_W-1:0] byte_count_next;
    logic [7:0]         frame_type_reg;
    logic [7:0]         payload_reg [PAYLOAD_BYTES];
    logic               in_hunt;
    logic               is_type;
    logic               is_payload;
    logic               is_close;
    logic [2:0]         payload_idx;
    logic [COUNT_W-1:0] pos_minus_start;

    // Decode the position of the incoming byte within the frame.
    assign in_hunt         = (byte_count_reg == '0);
    assign is_type         = (byte_count_reg == COUNT_W'(1));
    assign is_payload      = (byte_count_reg >= COUNT_W'(PAYLOAD_START)) &&
                             (byte_count_reg <  COUNT_W'(PAYLOAD_START + PAYLOAD_BYTES));
    assign is_close        = !in_hunt && ({1'b0, byte_count_reg} >= LAST_POS);
    assign pos_minus_start = byte_count_reg - COUNT_W'(PAYLOAD_START);
    assign payload_idx     = pos_minus_start[2:0];

    // Next byte count: open on a header, count through the frame, clear at its end.
    always_comb
    begin
        if (in_hunt)
            byte_count_next = (rx_byte == cfg.header_byte) ? COUNT_W'(1) : '0;
        else if (is_close)
            byte_count_next = '0;
        else
            byte_count_next = byte_count_reg + COUNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_count_reg <= '0;
        else if (step)
            byte_count_reg <= byte_count_next;
    end

    // Type and payload store; every frame rewrites all of it before closing.
    always_ff @(posedge clk)
    begin
        if (step && is_type)
            frame_type_reg <= rx_byte;
        if (step && is_payload)
            payload_reg[payload_idx] <= rx_byte;
    end

    // The result: the last byte closes an angle frame; the payload is already held.
    assign res_valid           = step && is_close && (frame_type_reg == cfg.angle_type_code);
    assign res.angle_x         = {payload_reg[1], payload_reg[0]};
    assign res.angle_y         = {payload_reg[3], payload_reg[2]};
    assign res.angle_z         = {payload_reg[5], payload_reg[4]};
    assign res.temperature_raw = {payload_reg[7], payload_reg[6]};

endmodule

### hdl/imu_angle_frame_parser.sv
// Top level of the IMU angle frame parser: input register, framer, result register.
// Depends on imu_afp_pkg, imu_afp_regs and imu_afp_framer.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid, in_stall, rx_byte) takes one received byte per
// item. The block hunts for frames of FRAME_LENGTH bytes opening with the
// header byte; a frame whose type byte matches the angle type code gives one
// result item on the output channel (out_valid, out_stall, angle_x, angle_y,
// angle_z, temperature_raw). Other frames and stray bytes give nothing.
// Throughput: one byte per cycle unless a result is stalled; the input
// register and the result register let a new byte enter while a finished
// result waits to be taken. When the receiver stalls with a result pending,
// the input register fills and in_stall rises on the next byte; no byte or
// result is lost. Reset (rst_n, asynchronous, active low) empties both
// registers, restarts the header hunt and loads header 0x55 and angle type
// 0x53. Registers must be written through the APB-style port at byte addresses
// 0 and 4, by the user only while idle; the block does not enforce it.
module imu_angle_frame_parser
#(
    parameter int FRAME_LENGTH = 11
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [imu_afp_pkg::PADDR_W-1:0] paddr,
    input  logic [imu_afp_pkg::PDATA_W-1:0] pwdata,
    output logic [imu_afp_pkg::PDATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      rx_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [15:0]              angle_x,
    output logic signed [15:0]              angle_y,
    output logic signed [15:0]              angle_z,
    output logic signed [15:0]              temperature_raw
);
    import imu_afp_pkg::*;

    afp_cfg_t    cfg;
    afp_result_t res;
    afp_result_t out_reg;
    logic        res_valid;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    logic        out_blocked;
    logic        advance;
    logic        in_take;

    imu_afp_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: the held byte moves on unless a result is stuck at the output.
    assign out_blocked = out_valid_reg && out_stall;
    assign advance     = in_valid_reg && !out_blocked;
    assign in_stall    = in_valid_reg && out_blocked;
    assign in_take     = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= rx_byte;
    end

    imu_afp_framer #(.FRAME_LENGTH(FRAME_LENGTH)) u_framer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_blocked)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            out_reg <= res;
    end

    assign out_valid       = out_valid_reg;
    assign angle_x         = out_reg.angle_x;
    assign angle_y         = out_reg.angle_y;
    assign angle_z         = out_reg.angle_z;
    assign temperature_raw = out_reg.temperature_raw;

endmodule

### hdl/imu_afp_checker.sv
// Port-level checker of the IMU angle frame parser, bound to the top level.
// Depends on imu_angle_frame_parser_defines.svh for the assertion macros.
`timescale 1ns / 1ps

`include "imu_angle_frame_parser_defines.svh"

module imu_afp_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] angle_x,
    input logic signed [15:0] angle_y,
    input logic signed [15:0] angle_z,
    input logic signed [15:0] temperature_raw
);

    // A stalled result stays valid.
    `AFP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // A stalled result keeps its payload.
    `AFP_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(angle_x) && $stable(angle_y) && $stable(angle_z) && $stable(temperature_raw))

    // The input side only stalls while a result is stuck at the output.
    `AFP_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

    // A fresh result comes from an earlier taken byte, passed on through the input register.
    `AFP_ASSERT_SAME(a_result_source, clk, rst_n, $rose(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind imu_angle_frame_parser imu_afp_checker u_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .angle_x         (angle_x),
    .angle_y         (angle_y),
    .angle_z         (angle_z),
    .temperature_raw (temperature_raw)
);

### tb/imu_angle_frame_parser_tb.sv
// Testbench of the IMU angle frame parser: byte stimulus, frame prediction and result checks.
// Depends on imu_afp_pkg and the imu_angle_frame_parser top level.
`timescale 1ns / 1ps

module imu_angle_frame_parser_tb;

    import imu_afp_pkg::*;

    localparam int FRAME_LEN    = 11;
    localparam int DRAIN_CYCLES = 8;

    // Stall patterns of the result receiver.
    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    logic [PDATA_W-1:0]  pwdata   = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [7:0]          rx_byte  = 8'h00;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic signed [15:0]  angle_x;
    logic signed [15:0]  angle_y;
    logic signed [15:0]  angle_z;
    logic signed [15:0]  temperature_raw;

    // Bytes waiting to be sent, and counts of bytes queued and taken by the block.
    logic [7:0]  rx_pending [$];
    int          rx_pushed   = 0;
    int          rx_accepted = 0;

    // Angle frames predicted but not yet seen on the output.
    afp_result_t angle_expected [$];
    int          errors = 0;

    // Mirror of the configuration registers.
    logic [7:0]  hdr_cfg  = HEADER_BYTE_RESET;
    logic [7:0]  type_cfg = ANGLE_TYPE_CODE_RESET;

    // Mirror of the framer state.
    logic [3:0]  frame_pos = 4'd0;
    logic [7:0]  frame_type_q = 8'h00;
    logic [7:0]  payload_q [0:7];

    // Sender burst and receiver stall state.
    int          gap_left   = 0;
    int          burst_left = 1;
    rx_mode_t    stall_mode = RX_FREE;
    int          mode_left  = 0;
    int          stall_run  = 0;

    imu_angle_frame_parser #(
        .FRAME_LENGTH (FRAME_LEN)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .angle_x         (angle_x),
        .angle_y         (angle_y),
        .angle_z         (angle_z),
        .temperature_raw (temperature_raw)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Advance the frame hunt by one taken byte and predict a finished angle frame.
    task automatic take_rx_byte(input logic [7:0] b);
        afp_result_t frame;
        if (frame_pos == 4'd0)
        begin
            if (b == hdr_cfg)
                frame_pos = 4'd1;
        end
        else
        begin
            if (frame_pos == 4'd1)
                frame_type_q = b;
            else if (frame_pos < 4'(PAYLOAD_START + PAYLOAD_BYTES))
                payload_q[3'(frame_pos - 4'(PAYLOAD_START))] = b;

            if (int'(frame_pos) + 1 >= FRAME_LEN)
            begin
                frame_pos = 4'd0;
                if (frame_type_q == type_cfg)
                begin
                    frame.angle_x         = {payload_q[1], payload_q[0]};
                    frame.angle_y         = {payload_q[3], payload_q[2]};
                    frame.angle_z         = {payload_q[5], payload_q[4]};
                    frame.temperature_raw = {payload_q[7], payload_q[6]};
                    angle_expected.push_back(frame);
                end
            end
            else
            begin
                frame_pos = frame_pos + 4'd1;
            end
        end
    endtask

    // Byte driver: bursts of items with random gaps, payload held while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                take_rx_byte(rx_byte);
                rx_accepted++;
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (rx_pending.size() > 0)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= rx_pending.pop_front();
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
            errors++;
        end
    endtask

    // Result monitor and receiver stall pattern.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        afp_result_t want;
        logic        next_stall;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (angle_expected.size() == 0)
                begin
                    $error("angle frame given with none expected");
                    errors++;
                end
                else
                begin
                    want = angle_expected.pop_front();
                    check_field("angle_x", want.angle_x, angle_x);
                    check_field("angle_y", want.angle_y, angle_y);
                    check_field("angle_z", want.angle_z, angle_z);
                    check_field("temperature_raw", want.temperature_raw, temperature_raw);
                end
            end

            if (mode_left == 0)
            begin
                stall_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(40, 300);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                RX_FREE:  next_stall = 1'b0;
                RX_LIGHT: next_stall = ($urandom_range(0, 3) == 0);
                RX_HEAVY: next_stall = ($urandom_range(0, 3) != 0);
                default:
                begin
                    if (stall_run > 0)
                    begin
                        stall_run--;
                        next_stall = 1'b1;
                    end
                    else if ($urandom_range(0, 15) == 0)
                    begin
                        stall_run  = $urandom_range(5, 20);
                        next_stall = 1'b1;
                    end
                    else
                    begin
                        next_stall = 1'b0;
                    end
                end
            endcase
            out_stall <= next_stall;
        end
    end

    task automatic push_rx(input logic [7:0] b);
        rx_pending.push_back(b);
        rx_pushed++;
    endtask

    // A full frame with the given header and type, random payload and checksum.
    task automatic push_frame(input logic [7:0] hdr, input logic [7:0] typ);
        push_rx(hdr);
        push_rx(typ);
        repeat (FRAME_LEN - 2) push_rx(8'($urandom_range(0, 255)));
    endtask

    // APB write: setup cycle, then access cycle; the register takes the value at its end.
    task automatic write_reg(input logic idx, input logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_HEADER_BYTE)
            hdr_cfg = value;
        else
            type_cfg = value;
    endtask

    // Wait until every queued byte is taken and every predicted frame has come out.
    task automatic wait_idle();
        while (rx_accepted != rx_pushed || angle_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One random phase: mostly well-formed frames, some foreign types,
    // truncated frames and stray bytes.
    task automatic run_random_phase(input logic [7:0] hdr, input logic [7:0] typ,
                                    input int budget);
        int counted;
        int pick;
        int n;
        counted = 0;
        write_reg(REG_HEADER_BYTE, hdr);
        write_reg(REG_ANGLE_TYPE_CODE, typ);
        while (counted < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                push_frame(hdr_cfg, type_cfg);
                counted += FRAME_LEN;
            end
            else if (pick < 75)
            begin
                push_frame(hdr_cfg, 8'($urandom_range(0, 255)));
                counted += FRAME_LEN;
            end
            else if (pick < 87)
            begin
                n = $urandom_range(0, 8);
                push_rx(hdr_cfg);
                push_rx(type_cfg);
                repeat (n) push_rx(8'($urandom_range(0, 255)));
                counted += n + 2;
            end
            else
            begin
                repeat ($urandom_range(1, 4)) push_rx(8'($urandom_range(0, 255)));
            end
        end
        wait_idle();
    endtask

    // Reset, directed cases, then random phases over several register settings.
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Stray bytes, an angle frame at the field extremes, and a foreign frame
        // carrying the header value inside its payload.
        push_rx(8'h00);
        push_rx(8'hFF);
        push_rx(8'h55); push_rx(8'h53);
        push_rx(8'h00); push_rx(8'h80); push_rx(8'hFF); push_rx(8'h7F);
        push_rx(8'h01); push_rx(8'h00); push_rx(8'hFF); push_rx(8'hFF);
        push_rx(8'h5A);
        push_rx(8'h55); push_rx(8'h51);
        push_rx(8'h55); push_rx(8'hAA); push_rx(8'h55); push_rx(8'hAA);
        push_rx(8'h00); push_rx(8'hFF); push_rx(8'h12); push_rx(8'h34);
        push_rx(8'h00);
        wait_idle();

        // Registers changed part-way through a frame: the header no longer
        // matters, and the type is judged against the value at close.
        push_rx(8'h55); push_rx(8'h53); push_rx(8'h11); push_rx(8'h22); push_rx(8'h33);
        wait_idle();
        write_reg(REG_HEADER_BYTE, 8'hAA);
        write_reg(REG_ANGLE_TYPE_CODE, 8'h99);
        push_rx(8'h44); push_rx(8'h55); push_rx(8'h66); push_rx(8'h77);
        push_rx(8'h88); push_rx(8'hC3);
        push_rx(8'h55);
        push_rx(8'hAA); push_rx(8'h53); push_rx(8'h01); push_rx(8'h02);
        wait_idle();
        write_reg(REG_ANGLE_TYPE_CODE, 8'h53);
        push_rx(8'h03); push_rx(8'h04); push_rx(8'h05); push_rx(8'h06);
        push_rx(8'h07); push_rx(8'h08); push_rx(8'hE0);
        wait_idle();

        run_random_phase(HEADER_BYTE_RESET, ANGLE_TYPE_CODE_RESET, 110);
        run_random_phase(8'h00, 8'h00, 110);
        run_random_phase(8'hFF, 8'hFF, 110);
        run_random_phase(8'h00, 8'hFF, 110);
        run_random_phase(8'hFF, 8'h00, 110);
        run_random_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 110);

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/imu_afp_pkg.sv
hdl/imu_afp_regs.sv
hdl/imu_afp_framer.sv
hdl/imu_angle_frame_parser.sv
hdl/imu_afp_checker.sv
tb/imu_angle_frame_parser_tb.sv
